FILE: rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared widths, register indexes and adder operation codes for the matrix
// symmetry checker.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int ELEM_W = 32;
  localparam int TOL_W  = 31;
  localparam int SIZE_W = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // Configuration register indexes.
  localparam logic REG_TOLERANCE   = 1'b0;
  localparam logic REG_MATRIX_SIZE = 1'b1;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_e;

endpackage

FILE: rtl/msc_alu.sv
// ----------------------------------------------------------------------------
// msc_alu
// Shared 33-bit adder: forms the exact difference or the exact sum of two
// signed Q16.16 elements.
// ----------------------------------------------------------------------------
module msc_alu
  import msc_pkg::*;
(
  input  alu_op_e                  op_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic signed [ELEM_W-1:0] b_i,
  output logic signed [ELEM_W:0]   sum_o
);

  logic [ELEM_W:0] a_ext;
  logic [ELEM_W:0] b_ext;
  logic [ELEM_W:0] b_opd;
  logic            carry;

  assign a_ext = {a_i[ELEM_W-1], a_i};
  assign b_ext = {b_i[ELEM_W-1], b_i};

  // Subtraction is an add of the inverted operand with a carry in.
  always_comb begin
    unique case (op_i)
      ALU_SUB: begin
        b_opd = ~b_ext;
        carry = 1'b1;
      end
      ALU_ADD: begin
        b_opd = b_ext;
        carry = 1'b0;
      end
      default: begin
        b_opd = b_ext;
        carry = 1'b0;
      end
    endcase
  end

  assign sum_o = $signed(a_ext + b_opd + {{ELEM_W{1'b0}}, carry});

endmodule

FILE: rtl/matrix_symmetry_check.sv
// ----------------------------------------------------------------------------
// matrix_symmetry_check
// Loads a square matrix, averages mirrored pairs that lie within tolerance
// and streams the matrix back out with a symmetry verdict.
// ----------------------------------------------------------------------------
// Usage. Elements arrive in row-major order on the input channel, one beat
// each, and are written straight into the matrix store: while loading, one
// element is taken per cycle. The beat that completes the matrix (load count
// reaching or passing the square of the size in force) starts the pair walk,
// and the input stalls until the whole matrix has been sent out again.
// The walk visits the lower triangle row by row. Each pair passes through
// the store's two read ports, the shared 33-bit adder and the single write
// port in these steps: read, difference and tolerance check, average and
// first write, second write. A pair outside tolerance ends the walk and
// clears the verdict. The output stream then reads each element through the
// registered store read and presents it as a beat before reading the next.
// While the receiver stalls, the beat and its payload are simply held.
// Reset clears the load count and the control state, sets the tolerance to
// zero and the size to eight; the store itself is not cleared, since every
// entry is written before it is read. Configuration writes are taken at any
// edge with the write enable high and should only be made while idle.
// ----------------------------------------------------------------------------
module matrix_symmetry_check
  import msc_pkg::*;
#(
  parameter int MAX_N = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port.
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [TOL_W-1:0]         cfg_data_i,
  // Input channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [ELEM_W-1:0] element_value_i,
  // Output channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ELEM_W-1:0] result_value_o,
  output logic                     symmetric_o,
  output logic                     last_of_matrix_o
);

  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // store address
  localparam int CW    = $clog2(DEPTH + 1);                 // load count
  localparam int NW    = $clog2(MAX_N + 1);                 // matrix size
  localparam int RW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;   // row / column

  // Sequencer states.
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_PRD  = 3'd1;
  localparam logic [2:0] S_PCHK = 3'd2;
  localparam logic [2:0] S_PAVG = 3'd3;
  localparam logic [2:0] S_PWR2 = 3'd4;
  localparam logic [2:0] S_ORD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [TOL_W-1:0]  tol_q;
  logic [SIZE_W-1:0] size_q;
  logic [CW-1:0]     load_cnt_q, load_cnt_d;
  logic [NW-1:0]     n_q, n_d;
  logic [CW-1:0]     total_q, total_d;
  logic              sym_q, sym_d;
  logic [RW-1:0]     r_q, r_d;
  logic [RW-1:0]     c_q, c_d;
  logic [AW-1:0]     base_q, base_d;
  logic [AW-1:0]     iu_q, iu_d;
  logic [AW-1:0]     k_q, k_d;
  logic [ELEM_W-1:0] avg_q;

  // Matrix store with one write port and two registered read ports.
  logic [ELEM_W-1:0] store_q [DEPTH];
  logic [ELEM_W-1:0] rd_a_q, rd_b_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ELEM_W-1:0] mem_wdata;
  logic              rd_en;
  logic [AW-1:0]     raddr_a, raddr_b;

  logic [NW-1:0]          n_eff;
  logic [CW-1:0]          total_now;
  logic [CW-1:0]          cnt_inc;
  logic [AW-1:0]          il;
  logic                   in_fire;
  logic                   out_fire;
  logic                   last_elem;
  alu_op_e                alu_op;
  logic signed [ELEM_W:0] alu_sum;
  logic signed [ELEM_W:0] tol_pos;
  logic signed [ELEM_W:0] tol_neg;
  logic                   out_of_tol;
  logic [ELEM_W-1:0]      avg;

  msc_alu u_alu (
    .op_i  (alu_op),
    .a_i   ($signed(rd_a_q)),
    .b_i   ($signed(rd_b_q)),
    .sum_o (alu_sum)
  );

  // A size of zero counts as one, and anything above the maximum is clamped.
  always_comb begin
    if (size_q == '0) begin
      n_eff = NW'(1);
    end else if (size_q > SIZE_W'(MAX_N)) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = NW'(size_q);
    end
  end

  assign total_now = CW'(n_eff) * CW'(n_eff);
  assign cnt_inc   = load_cnt_q + CW'(1);
  assign il        = base_q + AW'(c_q);

  assign in_fire   = (state_q == S_LOAD) && in_valid_i;
  assign out_fire  = (state_q == S_OUT) && !out_stall_i;
  assign last_elem = ((CW'(k_q) + CW'(1)) == total_q);

  // The pair is out of tolerance when the exact difference lies outside
  // the closed band from minus to plus tolerance.
  assign tol_pos    = $signed({2'b00, tol_q});
  assign tol_neg    = -tol_pos;
  assign out_of_tol = (alu_sum > tol_pos) || (alu_sum < tol_neg);

  // Floor average: the exact sum shifted right by one.
  assign avg = alu_sum[ELEM_W:1];

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    n_d        = n_q;
    total_d    = total_q;
    sym_d      = sym_q;
    r_d        = r_q;
    c_d        = c_q;
    base_d     = base_q;
    iu_d       = iu_q;
    k_d        = k_q;
    mem_we     = 1'b0;
    mem_waddr  = load_cnt_q[AW-1:0];
    mem_wdata  = element_value_i;
    rd_en      = 1'b0;
    raddr_a    = il;
    raddr_b    = iu_q;
    alu_op     = ALU_SUB;

    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          mem_we = 1'b1;
          if (cnt_inc >= total_now) begin
            load_cnt_d = '0;
            n_d        = n_eff;
            total_d    = total_now;
            sym_d      = 1'b1;
            r_d        = '0;
            c_d        = '0;
            base_d     = '0;
            iu_d       = '0;
            state_d    = S_PRD;
          end else begin
            load_cnt_d = cnt_inc;
          end
        end
      end
      S_PRD: begin
        rd_en   = 1'b1;
        state_d = S_PCHK;
      end
      S_PCHK: begin
        alu_op = ALU_SUB;
        if (out_of_tol) begin
          sym_d   = 1'b0;
          k_d     = '0;
          state_d = S_ORD;
        end else begin
          state_d = S_PAVG;
        end
      end
      S_PAVG: begin
        alu_op    = ALU_ADD;
        mem_we    = 1'b1;
        mem_waddr = il;
        mem_wdata = avg;
        state_d   = S_PWR2;
      end
      S_PWR2: begin
        mem_we    = 1'b1;
        mem_waddr = iu_q;
        mem_wdata = avg_q;
        if (c_q == r_q) begin
          if (NW'(r_q) == (n_q - NW'(1))) begin
            k_d     = '0;
            state_d = S_ORD;
          end else begin
            r_d     = r_q + RW'(1);
            c_d     = '0;
            base_d  = base_q + AW'(n_q);
            iu_d    = AW'(r_q) + AW'(1);
            state_d = S_PRD;
          end
        end else begin
          c_d     = c_q + RW'(1);
          iu_d    = iu_q + AW'(n_q);
          state_d = S_PRD;
        end
      end
      S_ORD: begin
        rd_en   = 1'b1;
        raddr_a = k_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_fire) begin
          if (last_elem) begin
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      tol_q      <= '0;
      size_q     <= SIZE_RESET;
      load_cnt_q <= '0;
      n_q        <= '0;
      total_q    <= '0;
      sym_q      <= 1'b0;
      r_q        <= '0;
      c_q        <= '0;
      base_q     <= '0;
      iu_q       <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      n_q        <= n_d;
      total_q    <= total_d;
      sym_q      <= sym_d;
      r_q        <= r_d;
      c_q        <= c_d;
      base_q     <= base_d;
      iu_q       <= iu_d;
      k_q        <= k_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_TOLERANCE:   tol_q  <= cfg_data_i;
          REG_MATRIX_SIZE: size_q <= cfg_data_i[SIZE_W-1:0];
          default:         tol_q  <= tol_q;
        endcase
      end
    end
  end

  // The average is kept for the mirrored write in the following cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_PAVG) begin
      avg_q <= avg;
    end
  end

  // Store array. The read registers only load when asked, so an output beat
  // held by a stalling receiver keeps its value.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_q <= store_q[raddr_a];
      rd_b_q <= store_q[raddr_b];
    end
  end

  assign in_stall_o       = (state_q != S_LOAD);
  assign out_valid_o      = (state_q == S_OUT);
  assign result_value_o   = $signed(rd_a_q);
  assign symmetric_o      = sym_q;
  assign last_of_matrix_o = last_elem;

endmodule

FILE: tb/matrix_symmetry_check_tb.sv
// ----------------------------------------------------------------------------
// matrix_symmetry_check_tb
// Self-checking bench for the matrix symmetry checker. Elements are sent as
// beats from a queue, every accepted element is folded into a shadow copy of
// the matrix store, and each completed matrix yields the beats that must come
// back: symmetrized values, verdict and end marker, compared field by field.
// ----------------------------------------------------------------------------
module matrix_symmetry_check_tb;
  import msc_pkg::*;

  localparam int MAX_N = 8;
  localparam logic [TOL_W-1:0] TOL_MAX = '1;
  localparam longint ELEM_MAX = 64'sd2147483647;
  localparam longint ELEM_MIN = -64'sd2147483648;
  // Worst case from idle to idle: pair walk plus the output stream of an 8x8.
  localparam int SETTLE_CYCLES = 2 * MAX_N * (MAX_N + 1) + 2 * MAX_N * MAX_N + 16;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ELEMENTS = 150;
  localparam int MISMATCH_PRINT_CAP = 100;

  typedef enum int {
    FILL_NEAR,
    FILL_BROKEN,
    FILL_NOISE
  } fill_e;

  typedef struct {
    logic [ELEM_W-1:0] value;
    int                gap;
  } pending_elem_t;

  typedef struct {
    logic [ELEM_W-1:0] value;
    logic              symmetric;
    logic              last;
  } result_beat_t;

  // Every input of the block has a known value from time zero.
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic                     cfg_index_i = REG_TOLERANCE;
  logic [TOL_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [ELEM_W-1:0] element_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ELEM_W-1:0] result_value_o;
  logic                     symmetric_o;
  logic                     last_of_matrix_o;

  matrix_symmetry_check #(
    .MAX_N(MAX_N)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_value_o  (result_value_o),
    .symmetric_o     (symmetric_o),
    .last_of_matrix_o(last_of_matrix_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the block: registers, store and load count.
  logic [TOL_W-1:0]  tol_shadow = '0;
  logic [SIZE_W-1:0] size_shadow = SIZE_RESET;
  logic [ELEM_W-1:0] store_shadow [64];
  logic [6:0]        count_shadow = '0;

  pending_elem_t pending_elems[$];
  result_beat_t  due_beats[$];

  // Knobs set by the stimulus process between phases. The receiver knobs are
  // read by the monitor at the clock edge, the sender knob when queueing.
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int holds_asked = 0;
  int holds_served = 0;

  int tx_gap_left = 0;
  int rx_stall_left = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int elements_queued = 0;

  // Sizes of zero count as one, sizes beyond the largest count as the largest.
  function automatic int effective_size(logic [SIZE_W-1:0] s);
    if (s == 0) begin
      return 1;
    end
    return (s > MAX_N) ? MAX_N : int'(s);
  endfunction

  // Takes one accepted element into the shadow store. The element that
  // completes the matrix triggers the pair walk over the lower triangle and
  // queues one result beat per element of the matrix.
  task automatic absorb_element(input logic [ELEM_W-1:0] v);
    int     n;
    int     total;
    int     il;
    int     iu;
    bit     fits;
    longint lo;
    longint up;
    longint gap_abs;
    longint avg;
    longint tol_l;
    n = effective_size(size_shadow);
    total = n * n;
    store_shadow[count_shadow[5:0]] = v;
    count_shadow = count_shadow + 7'd1;
    if (count_shadow < total) begin
      return;
    end
    count_shadow = '0;
    fits = 1'b1;
    tol_l = tol_shadow;
    for (int r = 0; r < n && fits; r++) begin
      for (int c = 0; c <= r && fits; c++) begin
        il = r * n + c;
        iu = c * n + r;
        lo = $signed(store_shadow[il]);
        up = $signed(store_shadow[iu]);
        gap_abs = (lo >= up) ? lo - up : up - lo;
        if (gap_abs > tol_l) begin
          fits = 1'b0;
        end else begin
          // Arithmetic shift of the exact sum rounds towards minus infinity.
          avg = (lo + up) >>> 1;
          store_shadow[il] = avg[ELEM_W-1:0];
          store_shadow[iu] = avg[ELEM_W-1:0];
        end
      end
    end
    for (int k = 0; k < total; k++) begin
      due_beats.push_back('{value: store_shadow[k], symmetric: fits, last: (k == total - 1)});
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [ELEM_W-1:0] got,
                               input logic [ELEM_W-1:0] want);
    if (mismatch_count < MISMATCH_PRINT_CAP) begin
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_result_beat();
    result_beat_t want;
    if (due_beats.size() == 0) begin
      flag_mismatch("result beat with nothing due", result_value_o, '0);
      return;
    end
    want = due_beats.pop_front();
    if (result_value_o !== want.value) begin
      flag_mismatch("result_value", result_value_o, want.value);
    end
    if (symmetric_o !== want.symmetric) begin
      flag_mismatch("symmetric", {31'd0, symmetric_o}, {31'd0, want.symmetric});
    end
    if (last_of_matrix_o !== want.last) begin
      flag_mismatch("last_of_matrix", {31'd0, last_of_matrix_o}, {31'd0, want.last});
    end
  endtask

  // Driver. A stalled beat is held unchanged; once it has been taken the
  // driver idles for the gap drawn with that element, then offers the next.
  always @(posedge clk_i or negedge rst_ni) begin : drive_elements
    pending_elem_t head;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      element_value_i <= '0;
      tx_gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        absorb_element(element_value_i);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_gap_left != 0) begin
          in_valid_i <= 1'b0;
          tx_gap_left <= tx_gap_left - 1;
        end else if (pending_elems.size() != 0) begin
          head = pending_elems.pop_front();
          in_valid_i <= 1'b1;
          element_value_i <= head.value;
          tx_gap_left <= head.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result beat taken is checked; after each one the receiver
  // draws how long it stalls. A long hold, when asked for, is counted here.
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    int stall_next;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_stall_left <= 0;
      holds_served <= 0;
    end else begin
      stall_next = rx_stall_left;
      if (out_valid_o && !out_stall_i) begin
        check_result_beat();
        stall_next = rx_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (holds_served != holds_asked) begin
        stall_next = LONG_HOLD;
        holds_served <= holds_asked;
      end
      if (stall_next != 0) begin
        out_stall_i <= 1'b1;
        rx_stall_left <= stall_next - 1;
      end else begin
        out_stall_i <= 1'b0;
        rx_stall_left <= 0;
      end
    end
  end

  // Watchdog: a long run of cycles without a beat on either side is a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[matrix_symmetry_check] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register writes happen only while the block is idle, so the shadow copy
  // can be updated at once.
  task automatic write_reg(input logic idx, input logic [TOL_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    if (idx == REG_TOLERANCE) begin
      tol_shadow = data;
    end else begin
      size_shadow = data[SIZE_W-1:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // The size register ignores the upper data bits, so they carry noise.
  task automatic write_size(input int s);
    logic [TOL_W-1:0] data;
    data = TOL_W'($urandom);
    data[SIZE_W-1:0] = s[SIZE_W-1:0];
    write_reg(REG_MATRIX_SIZE, data);
  endtask

  task automatic queue_element(input logic [ELEM_W-1:0] v);
    pending_elems.push_back('{value: v, gap: tx_idle_on ? $urandom_range(0, 9) : 0});
    elements_queued++;
  endtask

  // Waits until every element has been taken and every result has come back,
  // then lets the block settle before the next register write.
  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (pending_elems.size() != 0 || in_valid_i || due_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [ELEM_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 64) - 32;
      default: return $urandom;
    endcase
  endfunction

  // Builds one n by n matrix. Near-symmetric fills keep every mirrored pair
  // within the tolerance (hitting the limit exactly now and then); a broken
  // fill pushes one off-diagonal pair just past it; noise is unconstrained.
  task automatic queue_matrix(input int n, input fill_e fill);
    logic [ELEM_W-1:0] cells [64];
    longint a;
    longint b;
    longint d;
    int bad_r;
    int bad_c;
    bad_r = -1;
    bad_c = -1;
    if (n > 1) begin
      bad_r = $urandom_range(1, n - 1);
      bad_c = $urandom_range(0, bad_r - 1);
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c <= r; c++) begin
        a = $signed(pick_word());
        if (fill == FILL_NOISE) begin
          b = $signed(pick_word());
        end else begin
          if (fill == FILL_BROKEN && r == bad_r && c == bad_c) begin
            d = longint'(tol_shadow) + 1 + $urandom_range(0, 3);
          end else if ($urandom_range(0, 3) == 0) begin
            d = tol_shadow;
          end else begin
            d = $urandom_range(0, tol_shadow);
          end
          if ($urandom_range(0, 1) != 0) begin
            d = -d;
          end
          b = a + d;
          if (b > ELEM_MAX || b < ELEM_MIN) begin
            b = a - d;
          end
        end
        cells[r * n + c] = a[ELEM_W-1:0];
        if (r != c) begin
          cells[c * n + r] = b[ELEM_W-1:0];
        end
      end
    end
    for (int k = 0; k < n * n; k++) begin
      queue_element(cells[k]);
    end
  endtask

  initial begin
    int random_goal;
    int pick;
    int sz;
    int n;
    int count;
    fill_e fill;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: the extremes of the element range with zero tolerance, where
    // only equal pairs pass.
    write_size(2);
    write_reg(REG_TOLERANCE, '0);
    queue_element(32'h7FFF_FFFF);
    queue_element(32'd5);
    queue_element(32'd5);
    queue_element(32'h8000_0000);
    drain();

    // A pair exactly at the tolerance whose sum is odd and negative, so the
    // average has to round downwards.
    write_reg(REG_TOLERANCE, 31'd7);
    queue_element(-32'sd3);
    queue_element(-32'sd8);
    queue_element(-32'sd1);
    queue_element(32'h7FFF_FFFF);
    drain();

    // Largest tolerance, yet the opposite extremes still differ by more.
    write_reg(REG_TOLERANCE, TOL_MAX);
    queue_element(32'h8000_0000);
    queue_element(32'h8000_0000);
    queue_element(32'h7FFF_FFFF);
    queue_element(32'hFFFF_FFFD);
    drain();

    // A size of zero behaves as a single element.
    write_size(0);
    write_reg(REG_TOLERANCE, '0);
    queue_element(32'h8000_0000);
    drain();

    // Size shrunk in the middle of a load: the count already exceeds the new
    // square, so the next element completes the smaller matrix.
    write_size(3);
    write_reg(REG_TOLERANCE, 31'd100);
    repeat (5) queue_element(pick_word());
    drain();
    write_size(2);
    queue_element(pick_word());
    drain();

    // Size grown in the middle of a load.
    write_size(2);
    repeat (2) queue_element(pick_word());
    drain();
    write_size(3);
    repeat (7) queue_element(pick_word());
    drain();

    // An oversized setting behaves as the largest matrix.
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_size(15);
    write_reg(REG_TOLERANCE, TOL_W'($urandom_range(0, 1000)));
    queue_matrix(MAX_N, FILL_NEAR);
    drain();

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering beats, so the block fills and stalls its input.
    tx_idle_on = 1'b0;
    write_size(2);
    write_reg(REG_TOLERANCE, TOL_MAX);
    holds_asked++;
    repeat (4) queue_matrix(2, FILL_NOISE);
    drain();

    // Random phases: mostly small matrices, now and then the largest ones.
    random_goal = elements_queued + RANDOM_ELEMENTS;
    while (elements_queued < random_goal) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        sz = 0;
      end else if (pick == 1) begin
        sz = $urandom_range(9, 15);
      end else if (pick < 6) begin
        sz = $urandom_range(5, 8);
      end else begin
        sz = $urandom_range(1, 4);
      end
      write_size(sz);
      case ($urandom_range(0, 3))
        0: write_reg(REG_TOLERANCE, '0);
        1: write_reg(REG_TOLERANCE, TOL_MAX);
        2: write_reg(REG_TOLERANCE, TOL_W'($urandom_range(0, 64)));
        default: write_reg(REG_TOLERANCE, TOL_W'($urandom));
      endcase
      n = effective_size(sz[SIZE_W-1:0]);
      count = (n == MAX_N) ? 1 : $urandom_range(1, 3);
      repeat (count) begin
        pick = $urandom_range(0, 9);
        fill = (pick < 6) ? FILL_NEAR : (pick < 8) ? FILL_BROKEN : FILL_NOISE;
        queue_matrix(n, fill);
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("[matrix_symmetry_check] OK");
    end else begin
      $display("[matrix_symmetry_check] ERROR");
    end
    $finish;
  end

endmodule
